// ----- design/afft_pkg.sv -----
// shared types, codes and constants of the 2d affine point transform
`default_nettype none

package afft_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y = 3'd7;

  // transform modes
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_TRANSLATE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SCALE        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SCALE_PIVOT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ROTATE       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ROTATE_PIVOT = 3'd4;

  localparam int ANGLE_W = 10;
  localparam int FULL_TURN = 360;
  localparam int HALF_TURN = 180;
  localparam int QUARTER_TURN = 90;
  localparam int SCALE_ONE = 256;
  localparam int SCALE_FRAC = 8;

  // cordic: angle in q16 degrees, vectors in q30
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_CNT_W = 4;
  localparam int CORDIC_Q = 30;
  localparam int ANGLE_Q = 16;
  localparam int XW = 33;
  localparam int ZW = 26;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;

  localparam int COEF_W = 32;

  typedef struct packed {
    logic signed [COEF_W-1:0] xx;
    logic signed [COEF_W-1:0] yx;
    logic signed [COEF_W-1:0] tx;
    logic signed [COEF_W-1:0] xy;
    logic signed [COEF_W-1:0] yy;
    logic signed [COEF_W-1:0] ty;
  } coef_t;

  function automatic logic signed [ZW-1:0] atan_q16deg(input logic [CORDIC_CNT_W-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      4'd0:    r = 26'sd2949120;
      4'd1:    r = 26'sd1740967;
      4'd2:    r = 26'sd919879;
      4'd3:    r = 26'sd466945;
      4'd4:    r = 26'sd234379;
      4'd5:    r = 26'sd117304;
      4'd6:    r = 26'sd58666;
      4'd7:    r = 26'sd29335;
      4'd8:    r = 26'sd14668;
      4'd9:    r = 26'sd7334;
      4'd10:   r = 26'sd3667;
      4'd11:   r = 26'sd1833;
      4'd12:   r = 26'sd917;
      4'd13:   r = 26'sd458;
      4'd14:   r = 26'sd229;
      4'd15:   r = 26'sd115;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/afft_coef_build.sv -----
// configuration registers and coefficient builder with iterative cordic
`default_nettype none

module afft_coef_build #(
  parameter int FRAC_BITS = 14
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [afft_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [afft_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  output afft_pkg::coef_t                       coef_o,
  output logic                                  busy_o
);
  import afft_pkg::*;

  localparam int CW = FRAC_BITS + 3;
  localparam int BW = (CW > 17) ? CW : 17;
  localparam int PW = BW + 17;
  localparam int WW = PW + FRAC_BITS + 1;
  localparam int RS = CORDIC_Q - FRAC_BITS;
  localparam int SCL = FRAC_BITS - SCALE_FRAC;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FOLD = 3'd1;
  localparam logic [2:0] ST_ROT  = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam logic signed [CW-1:0] ONE_C = CW'(1) <<< FRAC_BITS;
  localparam logic signed [XW-1:0] HALF_X = XW'(1) <<< (RS - 1);
  localparam logic signed [XW-1:0] HALF_XM1 = HALF_X - XW'(1);

  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [WW-1:0] v);
    logic [WW-COEF_W:0] hi;
    logic signed [COEF_W-1:0] r;
    hi = v[WW-1:COEF_W-1];
    if ((&hi) || !(|hi)) begin
      r = v[COEF_W-1:0];
    end else if (v[WW-1]) begin
      r = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COEF_W-1){1'b1}}};
    end
    return r;
  endfunction

  logic [2:0]                  st_q, st_d;
  logic [CORDIC_CNT_W-1:0]     cnt_q, cnt_d;
  logic [MODE_W-1:0]           mode_q;
  logic signed [15:0]          shx_q, shy_q, scx_q, scy_q, pvx_q, pvy_q;
  logic signed [ANGLE_W-1:0]   ang_q;
  coef_t                       coef_q, coef_d;

  logic signed [XW-1:0]        x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]        z_q, z_d;
  logic                        neg_q, neg_d;
  logic signed [CW-1:0]        cos_q, cos_d, sin_q, sin_d;
  logic signed [PW-1:0]        prod_q [4];
  logic signed [PW-1:0]        prod;

  // angle folding
  logic signed [10:0]          t0, t1, t2, t3, t4, t5;
  logic signed [7:0]           a_fold;
  logic                        neg_fold;
  // cordic step and rounding
  logic signed [XW-1:0]        dx, dy, xs, ys;
  logic signed [CW-1:0]        cv, sv;
  // shared multiplier operands
  logic signed [16:0]          op_a, dsx, dsy;
  logic signed [BW-1:0]        op_b;
  logic signed [CW-1:0]        one_m_c;
  // wide coefficient values
  logic signed [WW-1:0]        wxx, wyx, wtx, wxy, wyy, wty;

  always_comb begin
    t0 = 11'(ang_q);
    t1 = (t0 < 0) ? t0 + 11'(FULL_TURN) : t0;
    t2 = (t1 < 0) ? t1 + 11'(FULL_TURN) : t1;
    t3 = (t2 >= 11'(FULL_TURN)) ? t2 - 11'(FULL_TURN) : t2;
    t4 = (t3 > 11'(HALF_TURN)) ? t3 - 11'(FULL_TURN) : t3;
    neg_fold = 1'b0;
    t5 = t4;
    if (t4 > 11'(QUARTER_TURN)) begin
      t5 = t4 - 11'(HALF_TURN);
      neg_fold = 1'b1;
    end else if (t4 < -11'(QUARTER_TURN)) begin
      t5 = t4 + 11'(HALF_TURN);
      neg_fold = 1'b1;
    end
    a_fold = 8'(t5);
  end

  always_comb begin
    dx = y_q >>> cnt_q;
    dy = x_q >>> cnt_q;
    // round half away from zero from q30 down to the coefficient format
    xs = (x_q + (x_q[XW-1] ? HALF_XM1 : HALF_X)) >>> RS;
    ys = (y_q + (y_q[XW-1] ? HALF_XM1 : HALF_X)) >>> RS;
    cv = CW'(xs);
    sv = CW'(ys);
  end

  always_comb begin
    one_m_c = ONE_C - cos_q;
    dsx = 17'(SCALE_ONE) - 17'(scx_q);
    dsy = 17'(SCALE_ONE) - 17'(scy_q);
    case (cnt_q[1:0])
      2'd0, 2'd3: op_a = 17'(pvx_q);
      default:    op_a = 17'(pvy_q);
    endcase
    op_b = '0;
    if (mode_q == MODE_ROTATE_PIVOT) begin
      op_b = cnt_q[0] ? BW'(sin_q) : BW'(one_m_c);
    end else if (mode_q == MODE_SCALE_PIVOT) begin
      if (cnt_q[1:0] == 2'd0) begin
        op_b = BW'(dsx);
      end else if (cnt_q[1:0] == 2'd2) begin
        op_b = BW'(dsy);
      end
    end
    prod = PW'(op_a) * PW'(op_b);
  end

  always_comb begin
    wxx = WW'(ONE_C);
    wyy = WW'(ONE_C);
    wyx = '0;
    wxy = '0;
    wtx = '0;
    wty = '0;
    case (mode_q)
      MODE_TRANSLATE: begin
        wtx = WW'(shx_q) <<< FRAC_BITS;
        wty = WW'(shy_q) <<< FRAC_BITS;
      end
      MODE_SCALE, MODE_SCALE_PIVOT: begin
        wxx = WW'(scx_q) <<< SCL;
        wyy = WW'(scy_q) <<< SCL;
        if (mode_q == MODE_SCALE_PIVOT) begin
          wtx = WW'(prod_q[0]) <<< SCL;
          wty = WW'(prod_q[2]) <<< SCL;
        end
      end
      MODE_ROTATE, MODE_ROTATE_PIVOT: begin
        wxx = WW'(cos_q);
        wyy = WW'(cos_q);
        wxy = WW'(sin_q);
        wyx = -WW'(sin_q);
        if (mode_q == MODE_ROTATE_PIVOT) begin
          wtx = WW'(prod_q[0]) + WW'(prod_q[1]);
          wty = WW'(prod_q[2]) - WW'(prod_q[3]);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_d = st_q;
    cnt_d = cnt_q;
    coef_d = coef_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    neg_d = neg_q;
    cos_d = cos_q;
    sin_d = sin_q;
    case (st_q)
      ST_IDLE: begin
      end
      ST_FOLD: begin
        x_d = CORDIC_GAIN;
        y_d = '0;
        z_d = ZW'($signed({a_fold, {ANGLE_Q{1'b0}}}));
        neg_d = neg_fold;
        cnt_d = '0;
        st_d = ST_ROT;
      end
      ST_ROT: begin
        if (!z_q[ZW-1]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_q16deg(cnt_q);
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_q16deg(cnt_q);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
          st_d = ST_RND;
        end
      end
      ST_RND: begin
        cos_d = neg_q ? -cv : cv;
        sin_d = neg_q ? -sv : sv;
        cnt_d = '0;
        st_d = ST_MUL;
      end
      ST_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[1:0] == 2'd3) begin
          st_d = ST_FIN;
        end
      end
      ST_FIN: begin
        coef_d.xx = sat32(wxx);
        coef_d.yx = sat32(wyx);
        coef_d.tx = sat32(wtx);
        coef_d.xy = sat32(wxy);
        coef_d.yy = sat32(wyy);
        coef_d.ty = sat32(wty);
        st_d = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
    // any register write restarts the rebuild
    if (cfg_we_i) begin
      st_d = ST_FOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      cnt_q <= '0;
      mode_q <= MODE_TRANSLATE;
      shx_q <= '0;
      shy_q <= '0;
      scx_q <= 16'(SCALE_ONE);
      scy_q <= 16'(SCALE_ONE);
      ang_q <= '0;
      pvx_q <= '0;
      pvy_q <= '0;
      coef_q.xx <= COEF_W'(ONE_C);
      coef_q.yx <= '0;
      coef_q.tx <= '0;
      coef_q.xy <= '0;
      coef_q.yy <= COEF_W'(ONE_C);
      coef_q.ty <= '0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      coef_q <= coef_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:    mode_q <= cfg_wdata_i[MODE_W-1:0];
          REG_SHIFT_X: shx_q <= cfg_wdata_i;
          REG_SHIFT_Y: shy_q <= cfg_wdata_i;
          REG_SCALE_X: scx_q <= cfg_wdata_i;
          REG_SCALE_Y: scy_q <= cfg_wdata_i;
          REG_ANGLE:   ang_q <= cfg_wdata_i[ANGLE_W-1:0];
          REG_PIVOT_X: pvx_q <= cfg_wdata_i;
          REG_PIVOT_Y: pvy_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    neg_q <= neg_d;
    cos_q <= cos_d;
    sin_q <= sin_d;
    if (st_q == ST_MUL) begin
      prod_q[cnt_q[1:0]] <= prod;
    end
  end

  assign coef_o = coef_q;
  assign busy_o = (st_q != ST_IDLE);

  a_write_starts_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy_o)
    else $error("register write did not start a coefficient rebuild");

  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(st_q) == ST_FIN)
    else $error("builder went idle without finishing the coefficients");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MUL) |-> (cnt_q[CORDIC_CNT_W-1:2] == '0))
    else $error("multiply step count out of range");

endmodule

`default_nettype wire

// ----- design/afft_pipe.sv -----
// four stage point pipeline: input, products, rounding, sum and saturation
`default_nettype none

module afft_pipe #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  afft_pkg::coef_t              coef_i,
  input  wire                          busy_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  signed [COORD_BITS-1:0] point_x_i,
  input  wire  signed [COORD_BITS-1:0] point_y_i,
  input  wire                          last_point_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o,
  output logic                         out_last_o,
  output logic                         clipped_o
);
  import afft_pkg::*;

  localparam int PW = COORD_BITS + COEF_W;
  localparam int RW = PW - FRAC_BITS;
  localparam int SW = RW + 2;
  localparam int TW = COEF_W + 1;

  localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] HALF_PM1 = HALF_P - PW'(1);
  localparam logic signed [TW-1:0] HALF_T = TW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [TW-1:0] HALF_TM1 = HALF_T - TW'(1);
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // drop the fraction, rounding half away from zero
  function automatic logic signed [RW-1:0] rnd_p(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + (p[PW-1] ? HALF_PM1 : HALF_P);
    return RW'(s >>> FRAC_BITS);
  endfunction

  function automatic logic signed [RW-1:0] rnd_t(input logic signed [COEF_W-1:0] c);
    logic signed [TW-1:0] s;
    s = TW'(c) + (c[COEF_W-1] ? HALF_TM1 : HALF_T);
    return RW'(s >>> FRAC_BITS);
  endfunction

  logic en1, en2, en3, en4;

  logic                         v1_q, l1_q;
  logic signed [COORD_BITS-1:0] x1_q, y1_q;
  logic                         v2_q, l2_q;
  logic signed [PW-1:0]         pxx_q, pyx_q, pxy_q, pyy_q;
  logic                         v3_q, l3_q;
  logic signed [RW-1:0]         rxx_q, ryx_q, rxy_q, ryy_q, rtx_q, rty_q;
  logic                         v4_q, l4_q, clip4_q;
  logic signed [COORD_BITS-1:0] ox_q, oy_q;

  logic signed [SW-1:0]         sum_x, sum_y;
  logic [SW-COORD_BITS:0]       hx, hy;
  logic                         ovf_x, ovf_y;
  logic signed [COORD_BITS-1:0] sat_x, sat_y;

  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  // rebuilding coefficients holds off new requests
  assign in_stall_o = !en1 || busy_i;

  always_comb begin
    sum_x = SW'(rxx_q) + SW'(ryx_q) + SW'(rtx_q);
    sum_y = SW'(rxy_q) + SW'(ryy_q) + SW'(rty_q);
    hx = sum_x[SW-1:COORD_BITS-1];
    hy = sum_y[SW-1:COORD_BITS-1];
    ovf_x = !((&hx) || !(|hx));
    ovf_y = !((&hy) || !(|hy));
    sat_x = ovf_x ? (sum_x[SW-1] ? C_MIN : C_MAX) : sum_x[COORD_BITS-1:0];
    sat_y = ovf_y ? (sum_y[SW-1] ? C_MIN : C_MAX) : sum_y[COORD_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i && !busy_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      x1_q <= point_x_i;
      y1_q <= point_y_i;
      l1_q <= last_point_i;
    end
    if (en2) begin
      pxx_q <= PW'(x1_q) * PW'($signed(coef_i.xx));
      pyx_q <= PW'(y1_q) * PW'($signed(coef_i.yx));
      pxy_q <= PW'(x1_q) * PW'($signed(coef_i.xy));
      pyy_q <= PW'(y1_q) * PW'($signed(coef_i.yy));
      l2_q <= l1_q;
    end
    if (en3) begin
      rxx_q <= rnd_p(pxx_q);
      ryx_q <= rnd_p(pyx_q);
      rxy_q <= rnd_p(pxy_q);
      ryy_q <= rnd_p(pyy_q);
      rtx_q <= rnd_t($signed(coef_i.tx));
      rty_q <= rnd_t($signed(coef_i.ty));
      l3_q <= l2_q;
    end
    if (en4) begin
      ox_q <= sat_x;
      oy_q <= sat_y;
      clip4_q <= ovf_x || ovf_y;
      l4_q <= l3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_x_o = ox_q;
  assign out_y_o = oy_q;
  assign out_last_o = l4_q;
  assign clipped_o = clip4_q;

  a_stage1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && en2) |=> v2_q)
    else $error("request lost between input and product stage");

  a_stage2_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && en3) |=> v3_q)
    else $error("request lost between product and rounding stage");

  a_clip_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |->
      (out_x_o == C_MAX || out_x_o == C_MIN || out_y_o == C_MAX || out_y_o == C_MIN))
    else $error("clip flag set without a saturated coordinate");

endmodule

`default_nettype wire

// ----- design/affine_point_transform_2d_unit.sv -----
// top level of the 2d affine point transform
`default_nettype none

// Transforms one vertex per clock, when not stalled, as [x y 1] times a 3x3
// affine matrix, with each product rounded half away from zero and the result
// saturated to the coordinate range. A request passes the input, product,
// rounding and sum stages in order, and the pipeline takes a new request every
// cycle while the output side keeps up and no rebuild is running. Any register
// write rebuilds the six coefficients, through the 16 iterations of the
// sine/cosine unit and four passes through the one shared pivot multiplier,
// during which in_stall_o stays high.
module affine_point_transform_2d_unit #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [afft_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [afft_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  signed [COORD_BITS-1:0]       point_x_i,
  input  wire  signed [COORD_BITS-1:0]       point_y_i,
  input  wire                                last_point_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic signed [COORD_BITS-1:0]       out_x_o,
  output logic signed [COORD_BITS-1:0]       out_y_o,
  output logic                               out_last_o,
  output logic                               clipped_o
);
  import afft_pkg::*;

  coef_t coef;
  logic  busy;

  afft_coef_build #(
    .FRAC_BITS (FRAC_BITS)
  ) u_build (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef),
    .busy_o      (busy)
  );

  afft_pipe #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coef_i       (coef),
    .busy_i       (busy),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .last_point_i (last_point_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_last_o   (out_last_o),
    .clipped_o    (clipped_o)
  );

endmodule

`default_nettype wire
